// ----- rtl/eswr_pkg.sv -----
`timescale 1ns / 1ps
package eswr_pkg;
	localparam int OP_W = 4;
	localparam int QDEPTH = 2;

	typedef enum logic [3:0] {
		OP_CONNECT    = 4'd0,
		OP_DISCONNECT = 4'd1,
		OP_TOGGLE     = 4'd2,
		OP_CONNECTED  = 4'd3,
		OP_PATH       = 4'd4,
		OP_SOURCES    = 4'd5,
		OP_DESTS      = 4'd6,
		OP_DROP       = 4'd7,
		OP_CLEAR      = 4'd8
	} op_t;

	localparam logic [6:0] COUNT_MAX = 7'd127;

	typedef struct packed {
		logic       answer;
		logic [6:0] count;
		logic       status;
	} res_t;
endpackage

// ----- rtl/edge_set_with_reachability_top.sv -----
`timescale 1ns / 1ps
// a table operation passes through the scan, apply and output states; clear, unused codes
// and a path query whose start is its target go straight to the output state
// path query: pops a node, checks it against the visited list, then scans the table to push
// its successors; a node popped again goes back to pop after the visited check
// throughput: one item at a time; the engine takes the next item once the result is taken
// reset clears the valid bits at once, so the table is empty; no clearing pass
module edge_set_with_reachability_top import eswr_pkg::*; #(
	parameter int MAX_EDGES = 64,
	parameter int ID_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [((OP_W + 3 * ID_BITS + 7) / 8) * 8 - 1:0] s_tdata, // op, source node, destination node, node_id
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [15:0]  m_tdata  // answer, count, status
);
	logic q_valid, q_ready;
	logic [OP_W-1:0] q_op;
	logic [ID_BITS-1:0] q_a, q_b;
	res_t res;

	eswr_front #(.ID_BITS(ID_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_op(s_tdata[OP_W-1:0]), .in_s(s_tdata[OP_W +: ID_BITS]),
		.in_d(s_tdata[OP_W + ID_BITS +: ID_BITS]),
		.in_n(s_tdata[OP_W + 2 * ID_BITS +: ID_BITS]),
		.q_valid(q_valid), .q_ready(q_ready),
		.q_op(q_op), .q_a(q_a), .q_b(q_b)
	);

	eswr_back #(.MAX_EDGES(MAX_EDGES), .ID_BITS(ID_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready),
		.q_op(q_op), .q_a(q_a), .q_b(q_b),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
	);

	assign m_tdata = {7'd0, res.status, res.count, res.answer};

`ifndef SYNTH
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[0] || m_tdata[8]) |-> m_tdata[7:1] == 7'd0)
		else $error("count with answer or status");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready |=> !q_ready)
		else $error("engine took a second item");
`endif
endmodule

// ----- rtl/eswr_front.sv -----
`timescale 1ns / 1ps
module eswr_front import eswr_pkg::*; #(
	parameter int ID_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OP_W-1:0]      in_op,
	input  logic [ID_BITS-1:0]   in_s,
	input  logic [ID_BITS-1:0]   in_d,
	input  logic [ID_BITS-1:0]   in_n,
	output logic                 q_valid,
	input  logic                 q_ready,
	output logic [OP_W-1:0]      q_op,
	output logic [ID_BITS-1:0]   q_a,
	output logic [ID_BITS-1:0]   q_b
);
	localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	logic [OP_W-1:0]    op_q [QDEPTH];
	logic [ID_BITS-1:0] a_q [QDEPTH];
	logic [ID_BITS-1:0] b_q [QDEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic [ID_BITS-1:0] a_in, b_in;
	logic push, pop;

	// drop node carries the node in the first id slot
	always_comb begin
		if (in_op == OP_DROP) begin
			a_in = in_n;
		end else begin
			a_in = in_s;
		end
		b_in = in_d;
	end

	assign in_ready = (cnt_q != (AW+1)'(QDEPTH));
	assign q_valid  = (cnt_q != '0);
	assign push = in_valid && in_ready;
	assign pop  = q_valid && q_ready;
	assign q_op = op_q[rp_q];
	assign q_a  = a_q[rp_q];
	assign q_b  = b_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wp_q] <= in_op;
			a_q[wp_q]  <= a_in;
			b_q[wp_q]  <= b_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(QDEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(QDEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

// ----- rtl/eswr_back.sv -----
`timescale 1ns / 1ps
module eswr_back import eswr_pkg::*; #(
	parameter int MAX_EDGES = 64,
	parameter int ID_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  logic [OP_W-1:0]    q_op,
	input  logic [ID_BITS-1:0] q_a,
	input  logic [ID_BITS-1:0] q_b,
	output logic               out_valid,
	input  logic               out_ready,
	output res_t               out_res
);
	localparam int EW = $clog2(MAX_EDGES);
	localparam int SD = MAX_EDGES + 1;
	localparam int SW = $clog2(SD + 1);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_SCAN  = 8'b00000010,
		ST_RD    = 8'b00000100,
		ST_APPLY = 8'b00001000,
		ST_POP   = 8'b00010000,
		ST_VIS   = 8'b00100000,
		ST_EXP   = 8'b01000000,
		ST_OUT   = 8'b10000000
	} st_t;

	st_t st_q;
	logic [ID_BITS-1:0] src_mem [MAX_EDGES];
	logic [ID_BITS-1:0] dst_mem [MAX_EDGES];
	logic [MAX_EDGES-1:0] valid_q;
	logic [ID_BITS-1:0] vis_mem [SD];
	logic [ID_BITS-1:0] stk_mem [SD];
	logic [SW-1:0] vcnt_q, sdep_q, vidx_q;
	logic [EW:0] idx_q;
	logic [OP_W-1:0] op_q;
	logic [ID_BITS-1:0] a_q, b_q, cur_q;
	logic [ID_BITS-1:0] es_rd_q, ed_rd_q, vis_rd_q, stk_rd_q;
	logic found_q, free_q, seen_q;
	logic [EW-1:0] fidx_q, freeidx_q;
	logic [6:0] cnt_q;
	res_t res_q;
	logic out_q;
	logic [EW-1:0] ei;

	assign ei = idx_q[EW-1:0];
	// the result register is held until taken, so the next item waits for it
	assign q_ready = (st_q == ST_IDLE) && !out_q;
	assign out_valid = out_q;
	assign out_res = res_q;

	// registered read ports, one lookup per cycle
	always_ff @(posedge clk) begin
		es_rd_q <= src_mem[ei];
		ed_rd_q <= dst_mem[ei];
		vis_rd_q <= vis_mem[vidx_q[SW-1:0] < SW'(SD) ? vidx_q : '0];
		stk_rd_q <= stk_mem[sdep_q == '0 ? '0 : sdep_q - 1'b1];
	end

	logic rd_v_q;
	logic [EW-1:0] rd_i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			valid_q <= '0;
			out_q <= 1'b0;
			vcnt_q <= '0;
			sdep_q <= '0;
			rd_v_q <= 1'b0;
		end else begin
			if (out_q && out_ready) out_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (q_valid && !out_q) begin
						op_q <= q_op;
						a_q <= q_a;
						b_q <= q_b;
						idx_q <= '0;
						found_q <= 1'b0;
						free_q <= 1'b0;
						cnt_q <= '0;
						rd_v_q <= 1'b0;
						res_q <= '0;
						if (q_op == OP_CLEAR) begin
							valid_q <= '0;
							st_q <= ST_OUT;
						end else if (q_op == OP_PATH) begin
							if (q_a == q_b) begin
								res_q.answer <= 1'b1;
								st_q <= ST_OUT;
							end else begin
								stk_mem[0] <= q_a;
								sdep_q <= SW'(1);
								vcnt_q <= '0;
								st_q <= ST_POP;
							end
						end else if (q_op > OP_CLEAR) begin
							st_q <= ST_OUT;
						end else begin
							st_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// idx_q addresses the read, rd_i_q tags the data in the next cycle
					rd_v_q <= (idx_q < (EW+1)'(MAX_EDGES));
					rd_i_q <= ei;
					if (rd_v_q && valid_q[rd_i_q]) begin
						case (op_q)
							OP_SOURCES: if (ed_rd_q == b_q && cnt_q != COUNT_MAX)
								cnt_q <= cnt_q + 1'b1;
							OP_DESTS: if (es_rd_q == a_q && cnt_q != COUNT_MAX)
								cnt_q <= cnt_q + 1'b1;
							OP_DROP: if (es_rd_q == a_q || ed_rd_q == a_q)
								valid_q[rd_i_q] <= 1'b0;
							default: if (es_rd_q == a_q && ed_rd_q == b_q) begin
								found_q <= 1'b1;
								fidx_q <= rd_i_q;
							end
						endcase
					end
					if (rd_v_q && !valid_q[rd_i_q] && !free_q) begin
						free_q <= 1'b1;
						freeidx_q <= rd_i_q;
					end
					if (idx_q < (EW+1)'(MAX_EDGES)) begin
						idx_q <= idx_q + 1'b1;
					end else if (!rd_v_q) begin
						st_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					res_q.count <= cnt_q;
					case (op_q)
						OP_CONNECT: if (!found_q) begin
							if (free_q) begin
								valid_q[freeidx_q] <= 1'b1;
								src_mem[freeidx_q] <= a_q;
								dst_mem[freeidx_q] <= b_q;
							end else res_q.status <= 1'b1;
						end
						OP_DISCONNECT: if (found_q) valid_q[fidx_q] <= 1'b0;
						OP_TOGGLE: if (found_q) valid_q[fidx_q] <= 1'b0;
						else if (free_q) begin
							valid_q[freeidx_q] <= 1'b1;
							src_mem[freeidx_q] <= a_q;
							dst_mem[freeidx_q] <= b_q;
							res_q.answer <= 1'b1;
						end else res_q.status <= 1'b1;
						OP_CONNECTED: res_q.answer <= found_q;
						default: ;
					endcase
					st_q <= ST_OUT;
				end
				ST_POP: begin
					// stk_rd_q is registered, so it holds the top in the cycle after it is addressed
					if (sdep_q == '0) begin
						st_q <= ST_OUT;
					end else if (rd_v_q) begin
						rd_v_q <= 1'b0;
						cur_q <= stk_rd_q;
						sdep_q <= sdep_q - 1'b1;
						if (stk_rd_q == b_q) begin
							res_q.answer <= 1'b1;
							st_q <= ST_OUT;
						end else begin
							vidx_q <= '0;
							seen_q <= 1'b0;
							st_q <= ST_VIS;
						end
					end else begin
						rd_v_q <= 1'b1;
					end
				end
				ST_VIS: begin
					rd_v_q <= (vidx_q < vcnt_q);
					if (rd_v_q && vis_rd_q == cur_q) seen_q <= 1'b1;
					if (vidx_q < vcnt_q) begin
						vidx_q <= vidx_q + 1'b1;
					end else if (!rd_v_q) begin
						if (seen_q || (rd_v_q && vis_rd_q == cur_q)) begin
							st_q <= ST_POP;
						end else begin
							if (vcnt_q < SW'(SD)) begin
								vis_mem[vcnt_q] <= cur_q;
								vcnt_q <= vcnt_q + 1'b1;
							end
							idx_q <= '0;
							st_q <= ST_EXP;
						end
					end
				end
				ST_EXP: begin
					rd_v_q <= (idx_q < (EW+1)'(MAX_EDGES));
					rd_i_q <= ei;
					if (rd_v_q && valid_q[rd_i_q] && es_rd_q == cur_q
							&& sdep_q < SW'(SD)) begin
						stk_mem[sdep_q] <= ed_rd_q;
						sdep_q <= sdep_q + 1'b1;
					end
					if (idx_q < (EW+1)'(MAX_EDGES)) begin
						idx_q <= idx_q + 1'b1;
					end else if (!rd_v_q) begin
						st_q <= ST_POP;
					end
				end
				ST_OUT: begin
					out_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
